/* hw/rtl/tcis_pkg.sv */
`default_nettype none

package tcis_pkg;

	localparam int unsigned NumRegs         = 11;
	localparam int unsigned RamDepthDefault = 64;
	localparam int unsigned PtrSpan         = 256;

	localparam logic [3:0] RegIo   = 4'd1;
	localparam logic [3:0] RegMem  = 4'd7;
	localparam logic [3:0] RegRp   = 4'd8;
	localparam logic [3:0] RegIp   = 4'd9;
	localparam logic [3:0] RegFlag = 4'd10;

	localparam logic [7:0] FlagSet = 8'd128;

	typedef enum logic [4:0] {
		OP_ADD   = 5'd1,
		OP_SUB   = 5'd2,
		OP_MUL   = 5'd3,
		OP_OR    = 5'd4,
		OP_NOR   = 5'd5,
		OP_AND   = 5'd6,
		OP_NAND  = 5'd7,
		OP_XOR   = 5'd8,
		OP_XNOR  = 5'd9,
		OP_NOT   = 5'd10,
		OP_SHL   = 5'd11,
		OP_SHR   = 5'd12,
		OP_INC   = 5'd13,
		OP_GT    = 5'd14,
		OP_LT    = 5'd15,
		OP_EQ    = 5'd17,
		OP_GE    = 5'd18,
		OP_LE    = 5'd19,
		OP_NE    = 5'd20,
		OP_DEC   = 5'd21,
		OP_COPY  = 5'd22,
		OP_LDI   = 5'd23,
		OP_JMP   = 5'd24,
		OP_JMPI  = 5'd25,
		OP_POP   = 5'd26,
		OP_PUSH  = 5'd27,
		OP_PUSHI = 5'd28,
		OP_HALT  = 5'd29
	} op_e;

	typedef logic [NumRegs-1:0][7:0] regs_t;

	typedef struct packed {
		logic [4:0]  cmd;
		logic [10:0] operand_bits;
	} in_t;

	typedef struct packed {
		logic [7:0] next_ip;
		logic       io_valid;
		logic [7:0] io_data;
		logic       halted;
	} out_t;

	typedef struct packed {
		regs_t      regs;
		logic       ram_we;
		logic [7:0] ram_wptr;
		logic [7:0] ram_wdata;
		logic       reload;
		logic [7:0] reload_ptr;
		out_t       res;
	} exec_t;

	// Indices past the flag register read as zero.
	function automatic logic [7:0] reg_read(regs_t r, logic [3:0] idx);
		logic [7:0] v;
		v = 8'd0;
		if (idx <= RegFlag) begin
			v = r[idx];
		end
		return v;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/tiny_cpu_instruction_step_core.sv */
// Executes one instruction of a small 8-bit CPU per beat on the instr channel
// and returns one beat on the result channel: the next fetch address, an IO
// write (io_valid with io_data) and a halt mark. Both channels are
// valid/ready; the payloads are tcis_pkg::in_t and tcis_pkg::out_t.
// An accepted instruction sits in an input register, executes there and
// lands in the result register behind result_valid; for most instructions
// nothing else lies between acceptance and result. An instruction that
// moves the stack pointer adds a stack RAM read that refills the memory
// window, and POP adds its own registered read before that (only that one
// when it leaves the pointer where it was). Throughput is one instruction
// per cycle while the result channel takes each beat, except for those,
// which hold the execute register for their extra reads.
// The result register is separate from the execute stage, so a new
// instruction is accepted while a result waits; when result_ready stays low
// the finished instruction holds in the execute stage and instr_ready drops.
// Reset clears all eleven registers and marks every stack RAM entry as zero
// at once; the block accepts instructions in the first cycle after reset.
`default_nettype none

module tiny_cpu_instruction_step_core #(
	parameter int unsigned RAM_DEPTH = tcis_pkg::RamDepthDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            instr_valid,
	output logic            instr_ready,
	input  tcis_pkg::in_t   instr,
	output logic            result_valid,
	input  logic            result_ready,
	output tcis_pkg::out_t  result
);

	localparam int unsigned AddrW = $clog2(RAM_DEPTH);

	typedef enum logic [1:0] {
		ST_EXEC,
		ST_POP,
		ST_RELOAD
	} state_t;

	state_t            state_q, state_d;
	tcis_pkg::regs_t   regs_q, regs_d;
	tcis_pkg::in_t     instr_s1;
	logic [7:0]        a_s1, b_s1;
	logic              valid_s1;
	tcis_pkg::out_t    pend_q;
	tcis_pkg::out_t    result_q;
	logic              result_valid_q;
	tcis_pkg::exec_t   ex;
	tcis_pkg::out_t    res_d;

	logic              accept, done, go_commit, start_reload, slot_free, is_pop;
	logic              ram_we, rd_en;
	logic [AddrW-1:0]  ram_waddr, rd_addr;
	logic [7:0]        ram_rdata;
	logic [7:0]        pop_ptr;
	logic [7:0]        a_d, b_d;

	// Stack pointer to RAM slot, the pointer modulo the depth.
	logic [AddrW-1:0]  slot_tab [tcis_pkg::PtrSpan];

	for (genvar g = 0; g < tcis_pkg::PtrSpan; g++) begin : g_slot
		localparam int unsigned Slot = g % RAM_DEPTH;
		assign slot_tab[g] = AddrW'(Slot);
	end

	tcis_exec u_exec (
		.regs         (regs_q),
		.op           (instr_s1.cmd),
		.operand_bits (instr_s1.operand_bits),
		.a            (a_s1),
		.b            (b_s1),
		.pop_data     (ram_rdata),
		.ex           (ex)
	);

	tcis_stack_ram #(
		.DEPTH (RAM_DEPTH),
		.AW    (AddrW)
	) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ex.ram_wdata),
		.re     (rd_en),
		.raddr  (rd_addr),
		.rdata  (ram_rdata)
	);

	assign slot_free = !result_valid_q || result_ready;
	assign is_pop    = (instr_s1.cmd == tcis_pkg::OP_POP);
	assign pop_ptr   = regs_q[tcis_pkg::RegRp] - 8'd1;
	assign ram_waddr = slot_tab[ex.ram_wptr];

	always_comb begin
		regs_d       = regs_q;
		state_d      = state_q;
		ram_we       = 1'b0;
		rd_en        = 1'b0;
		rd_addr      = slot_tab[ex.reload_ptr];
		done         = 1'b0;
		go_commit    = 1'b0;
		start_reload = 1'b0;
		res_d        = ex.res;

		unique case (state_q)
			ST_EXEC: begin
				if (valid_s1) begin
					if (is_pop) begin
						rd_en   = 1'b1;
						rd_addr = slot_tab[pop_ptr];
						state_d = ST_POP;
					end else begin
						go_commit = 1'b1;
					end
				end
			end
			ST_POP: go_commit = 1'b1;
			ST_RELOAD: begin
				if (slot_free) begin
					regs_d[tcis_pkg::RegMem] = ram_rdata;
					res_d                    = pend_q;
					done                     = 1'b1;
					state_d                  = ST_EXEC;
				end
			end
			default: state_d = ST_EXEC;
		endcase

		// Register writes commit once; the window refill follows in ST_RELOAD.
		if (go_commit) begin
			if (ex.reload) begin
				regs_d       = ex.regs;
				ram_we       = ex.ram_we;
				rd_en        = 1'b1;
				start_reload = 1'b1;
				state_d      = ST_RELOAD;
			end else if (slot_free) begin
				regs_d  = ex.regs;
				ram_we  = ex.ram_we;
				done    = 1'b1;
				state_d = ST_EXEC;
			end
		end
	end

	assign instr_ready = !valid_s1 || done;
	assign accept      = instr_valid && instr_ready;

	// Operands are read from the state that the finishing instruction leaves.
	assign a_d = tcis_pkg::reg_read(regs_d, instr.operand_bits[10:7]);
	assign b_d = tcis_pkg::reg_read(regs_d, {1'b0, instr.operand_bits[6:4]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_EXEC;
			regs_q         <= '0;
			valid_s1       <= 1'b0;
			instr_s1       <= '0;
			a_s1           <= 8'd0;
			b_s1           <= 8'd0;
			pend_q         <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			state_q <= state_d;
			regs_q  <= regs_d;
			if (accept) begin
				valid_s1 <= 1'b1;
				instr_s1 <= instr;
				a_s1     <= a_d;
				b_s1     <= b_d;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end
			if (start_reload) begin
				pend_q <= ex.res;
			end
			if (done) begin
				result_valid_q <= 1'b1;
				result_q       <= res_d;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

/* hw/rtl/tcis_exec.sv */
`default_nettype none

module tcis_exec (
	input  tcis_pkg::regs_t regs,
	input  logic [4:0]      op,
	input  logic [10:0]     operand_bits,
	input  logic [7:0]      a,
	input  logic [7:0]      b,
	input  logic [7:0]      pop_data,
	output tcis_pkg::exec_t ex
);

	always_comb begin
		tcis_pkg::regs_t nr;
		logic [3:0] ic;
		logic [7:0] imm;
		logic [7:0] rp0;
		logic [7:0] mem0;
		logic [7:0] io0;
		logic [7:0] ip0;
		logic       wr_en;
		logic [7:0] wr_val;
		logic       cmp;
		logic       flag;
		logic       halt;

		nr     = regs;
		rp0    = regs[tcis_pkg::RegRp];
		mem0   = regs[tcis_pkg::RegMem];
		io0    = regs[tcis_pkg::RegIo];
		ip0    = regs[tcis_pkg::RegIp];
		imm    = operand_bits[10:3];
		ic     = operand_bits[3:0];
		wr_en  = 1'b0;
		wr_val = 8'd0;
		cmp    = 1'b0;
		flag   = 1'b0;
		halt   = 1'b0;
		ex     = '0;

		if (op == tcis_pkg::OP_LDI || op == tcis_pkg::OP_JMPI || op == tcis_pkg::OP_PUSHI) begin
			ic = {1'b0, operand_bits[2:0]};
		end

		unique case (op)
			tcis_pkg::OP_ADD: begin wr_en = 1'b1; wr_val = a + b; end
			tcis_pkg::OP_SUB: begin wr_en = 1'b1; wr_val = a - b; end
			tcis_pkg::OP_MUL: begin
				wr_en  = 1'b1;
				wr_val = {4'd0, a[3:0]} * {4'd0, b[3:0]};
			end
			tcis_pkg::OP_OR:   begin wr_en = 1'b1; wr_val = a | b; end
			tcis_pkg::OP_NOR:  begin wr_en = 1'b1; wr_val = ~(a | b); end
			tcis_pkg::OP_AND:  begin wr_en = 1'b1; wr_val = a & b; end
			tcis_pkg::OP_NAND: begin wr_en = 1'b1; wr_val = ~(a & b); end
			tcis_pkg::OP_XOR:  begin wr_en = 1'b1; wr_val = a ^ b; end
			tcis_pkg::OP_XNOR: begin wr_en = 1'b1; wr_val = ~(a ^ b); end
			tcis_pkg::OP_NOT:  begin wr_en = 1'b1; wr_val = ~a; end
			tcis_pkg::OP_SHL: begin
				wr_en  = 1'b1;
				wr_val = (b >= 8'd8) ? 8'd0 : (a << b[2:0]);
			end
			tcis_pkg::OP_SHR: begin
				wr_en  = 1'b1;
				wr_val = (b >= 8'd8) ? 8'd0 : (a >> b[2:0]);
			end
			tcis_pkg::OP_INC:  begin wr_en = 1'b1; wr_val = a + 8'd1; end
			tcis_pkg::OP_GT:   begin cmp = 1'b1; flag = (a > b); end
			tcis_pkg::OP_LT:   begin cmp = 1'b1; flag = (a < b); end
			tcis_pkg::OP_EQ:   begin cmp = 1'b1; flag = (a == b); end
			tcis_pkg::OP_GE:   begin cmp = 1'b1; flag = (a >= b); end
			tcis_pkg::OP_LE:   begin cmp = 1'b1; flag = (a <= b); end
			tcis_pkg::OP_NE:   begin cmp = 1'b1; flag = (a != b); end
			tcis_pkg::OP_DEC:  begin wr_en = 1'b1; wr_val = a - 8'd1; end
			tcis_pkg::OP_COPY: begin wr_en = 1'b1; wr_val = a; end
			tcis_pkg::OP_LDI:  begin wr_en = 1'b1; wr_val = imm; end
			tcis_pkg::OP_JMP: begin
				if (regs[tcis_pkg::RegFlag] == tcis_pkg::FlagSet) begin
					nr[tcis_pkg::RegIp] = a;
				end
			end
			tcis_pkg::OP_JMPI: begin
				if (regs[tcis_pkg::RegFlag] == tcis_pkg::FlagSet) begin
					nr[tcis_pkg::RegIp] = imm;
				end
			end
			tcis_pkg::OP_POP: begin
				// The pointer moves first, so a pop into RP overrides the decrement.
				nr[tcis_pkg::RegRp] = rp0 - 8'd1;
				wr_en               = 1'b1;
				wr_val              = pop_data;
			end
			tcis_pkg::OP_PUSH: begin
				ex.ram_we           = 1'b1;
				ex.ram_wdata        = a;
				nr[tcis_pkg::RegRp] = rp0 + 8'd1;
			end
			tcis_pkg::OP_PUSHI: begin
				ex.ram_we           = 1'b1;
				ex.ram_wdata        = imm;
				nr[tcis_pkg::RegRp] = rp0 + 8'd1;
			end
			tcis_pkg::OP_HALT: halt = 1'b1;
			default: ;
		endcase

		if (wr_en && ic <= tcis_pkg::RegFlag) begin
			nr[ic] = wr_val;
		end
		if (cmp) begin
			nr[tcis_pkg::RegFlag] = flag ? tcis_pkg::FlagSet : 8'd0;
		end

		// A moved stack pointer reloads the memory window; otherwise a changed
		// window is stored back at the old pointer.
		if (!halt) begin
			if (nr[tcis_pkg::RegRp] != rp0) begin
				ex.reload = 1'b1;
			end else if (nr[tcis_pkg::RegMem] != mem0) begin
				ex.ram_we    = 1'b1;
				ex.ram_wdata = nr[tcis_pkg::RegMem];
			end
			if (nr[tcis_pkg::RegIo] != io0) begin
				ex.res.io_valid     = 1'b1;
				ex.res.io_data      = nr[tcis_pkg::RegIo];
				nr[tcis_pkg::RegIo] = io0;
			end
		end

		if (nr[tcis_pkg::RegIp] == ip0) begin
			nr[tcis_pkg::RegIp] = ip0 + 8'd1;
		end

		ex.regs        = nr;
		ex.ram_wptr    = rp0;
		ex.reload_ptr  = nr[tcis_pkg::RegRp];
		ex.res.next_ip = nr[tcis_pkg::RegIp];
		ex.res.halted  = halt;
	end

endmodule

`default_nettype wire

/* hw/rtl/tcis_stack_ram.sv */
`default_nettype none

module tcis_stack_ram #(
	parameter int unsigned DEPTH = tcis_pkg::RamDepthDefault,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] written_q;
	logic [7:0]       rd_q;
	logic             rd_written_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	// Entries never written since reset read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (we) begin
				written_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_written_q <= written_q[raddr];
			end
		end
	end

	assign rdata = rd_written_q ? rd_q : 8'd0;

endmodule

`default_nettype wire

/* hw/rtl/tcis_checker.sv */
`default_nettype none

module tcis_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           instr_valid,
	input wire logic           instr_ready,
	input wire tcis_pkg::in_t  instr,
	input wire logic           result_valid,
	input wire logic           result_ready,
	input wire tcis_pkg::out_t result
);

	// A stalled result beat keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// HALT skips the IO sync, so it never reports an IO write.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.halted |-> !result.io_valid)
		else $error("halt beat carries an IO write");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.io_valid |-> result.io_data == 8'd0)
		else $error("io_data nonzero without io_valid");

	// HALT touches no RAM, so it passes from the input register straight to the
	// result register when the receiver takes the previous beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		instr_valid && instr_ready && instr.cmd == tcis_pkg::OP_HALT ##1 result_ready
		|=> result_valid && result.halted)
		else $error("halt result late");

endmodule

bind tiny_cpu_instruction_step_core tcis_checker u_tcis_checker (.*);

`default_nettype wire

/* dv/tcis_step_checker.sv */
module tcis_step_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           instr_valid,
	input  logic           instr_ready,
	input  tcis_pkg::in_t  instr,
	input  logic           result_valid,
	input  logic           result_ready,
	input  tcis_pkg::out_t result,
	output int unsigned    mismatches,
	output int unsigned    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned StackDepth = tcis_pkg::RamDepthDefault;
	localparam int unsigned SlotW      = $clog2(StackDepth);

	logic [7:0]     cpu_regs [tcis_pkg::NumRegs];
	logic [7:0]     stack_mem [StackDepth];
	tcis_pkg::out_t step_results_q [$];

	function automatic logic [7:0] read_reg(logic [3:0] idx);
		logic [7:0] v;
		v = 8'd0;
		if (idx < tcis_pkg::NumRegs) begin
			v = cpu_regs[idx];
		end
		return v;
	endfunction

	function automatic void write_reg(logic [3:0] idx, logic [7:0] v);
		if (idx < tcis_pkg::NumRegs) begin
			cpu_regs[idx] = v;
		end
	endfunction

	function automatic logic [SlotW-1:0] stack_slot(logic [7:0] rp);
		return SlotW'(rp % StackDepth);
	endfunction

	// Runs one instruction on the shadow CPU and returns the beat it should produce.
	function automatic tcis_pkg::out_t execute_instr(tcis_pkg::in_t ins);
		logic [7:0] imm, a, b, rp0, mem0, io0, ip0;
		logic [3:0] ia, ib, ic;
		logic       is_cmp, set_flag, halt;
		tcis_pkg::out_t res;
		imm = ins.operand_bits[10:3];
		ia = ins.operand_bits[10:7];
		ib = {1'b0, ins.operand_bits[6:4]};
		ic = ins.operand_bits[3:0];
		rp0 = cpu_regs[tcis_pkg::RegRp];
		mem0 = cpu_regs[tcis_pkg::RegMem];
		io0 = cpu_regs[tcis_pkg::RegIo];
		ip0 = cpu_regs[tcis_pkg::RegIp];
		is_cmp = 1'b0;
		set_flag = 1'b0;
		halt = 1'b0;
		if (ins.cmd == tcis_pkg::OP_LDI || ins.cmd == tcis_pkg::OP_JMPI
				|| ins.cmd == tcis_pkg::OP_PUSHI) begin
			ic = {1'b0, ins.operand_bits[2:0]};
		end
		a = read_reg(ia);
		b = read_reg(ib);

		case (ins.cmd)
			tcis_pkg::OP_ADD:  write_reg(ic, a + b);
			tcis_pkg::OP_SUB:  write_reg(ic, a - b);
			tcis_pkg::OP_MUL:  write_reg(ic, {4'd0, a[3:0]} * {4'd0, b[3:0]});
			tcis_pkg::OP_OR:   write_reg(ic, a | b);
			tcis_pkg::OP_NOR:  write_reg(ic, ~(a | b));
			tcis_pkg::OP_AND:  write_reg(ic, a & b);
			tcis_pkg::OP_NAND: write_reg(ic, ~(a & b));
			tcis_pkg::OP_XOR:  write_reg(ic, a ^ b);
			tcis_pkg::OP_XNOR: write_reg(ic, ~(a ^ b));
			tcis_pkg::OP_NOT:  write_reg(ic, ~a);
			tcis_pkg::OP_SHL:  write_reg(ic, (b >= 8'd8) ? 8'd0 : 8'(a << b));
			tcis_pkg::OP_SHR:  write_reg(ic, (b >= 8'd8) ? 8'd0 : 8'(a >> b));
			tcis_pkg::OP_INC:  write_reg(ic, a + 8'd1);
			tcis_pkg::OP_DEC:  write_reg(ic, a - 8'd1);
			tcis_pkg::OP_COPY: write_reg(ic, a);
			tcis_pkg::OP_LDI:  write_reg(ic, imm);
			tcis_pkg::OP_GT: begin
				is_cmp = 1'b1;
				set_flag = a > b;
			end
			tcis_pkg::OP_LT: begin
				is_cmp = 1'b1;
				set_flag = a < b;
			end
			tcis_pkg::OP_EQ: begin
				is_cmp = 1'b1;
				set_flag = a == b;
			end
			tcis_pkg::OP_GE: begin
				is_cmp = 1'b1;
				set_flag = a >= b;
			end
			tcis_pkg::OP_LE: begin
				is_cmp = 1'b1;
				set_flag = a <= b;
			end
			tcis_pkg::OP_NE: begin
				is_cmp = 1'b1;
				set_flag = a != b;
			end
			tcis_pkg::OP_JMP: begin
				if (cpu_regs[tcis_pkg::RegFlag] == tcis_pkg::FlagSet) begin
					cpu_regs[tcis_pkg::RegIp] = a;
				end
			end
			tcis_pkg::OP_JMPI: begin
				if (cpu_regs[tcis_pkg::RegFlag] == tcis_pkg::FlagSet) begin
					cpu_regs[tcis_pkg::RegIp] = imm;
				end
			end
			tcis_pkg::OP_POP: begin
				cpu_regs[tcis_pkg::RegRp] = cpu_regs[tcis_pkg::RegRp] - 8'd1;
				write_reg(ic, stack_mem[stack_slot(cpu_regs[tcis_pkg::RegRp])]);
			end
			tcis_pkg::OP_PUSH: begin
				stack_mem[stack_slot(cpu_regs[tcis_pkg::RegRp])] = a;
				cpu_regs[tcis_pkg::RegRp] = cpu_regs[tcis_pkg::RegRp] + 8'd1;
			end
			tcis_pkg::OP_PUSHI: begin
				stack_mem[stack_slot(cpu_regs[tcis_pkg::RegRp])] = imm;
				cpu_regs[tcis_pkg::RegRp] = cpu_regs[tcis_pkg::RegRp] + 8'd1;
			end
			tcis_pkg::OP_HALT: halt = 1'b1;
			default: ;
		endcase
		if (is_cmp) begin
			cpu_regs[tcis_pkg::RegFlag] = set_flag ? tcis_pkg::FlagSet : 8'd0;
		end

		res = '0;
		// A moved stack pointer wins over a window write: the window is refilled.
		if (!halt) begin
			if (cpu_regs[tcis_pkg::RegRp] != rp0) begin
				cpu_regs[tcis_pkg::RegMem] = stack_mem[stack_slot(cpu_regs[tcis_pkg::RegRp])];
			end else if (cpu_regs[tcis_pkg::RegMem] != mem0) begin
				stack_mem[stack_slot(rp0)] = cpu_regs[tcis_pkg::RegMem];
			end
			if (cpu_regs[tcis_pkg::RegIo] != io0) begin
				res.io_valid = 1'b1;
				res.io_data = cpu_regs[tcis_pkg::RegIo];
				cpu_regs[tcis_pkg::RegIo] = io0;
			end
		end
		if (cpu_regs[tcis_pkg::RegIp] == ip0) begin
			cpu_regs[tcis_pkg::RegIp] = ip0 + 8'd1;
		end
		res.next_ip = cpu_regs[tcis_pkg::RegIp];
		res.halted = halt;
		return res;
	endfunction

	function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tcis_pkg::out_t want;
		if (!arst_n) begin
			foreach (cpu_regs[i]) cpu_regs[i] = 8'd0;
			foreach (stack_mem[i]) stack_mem[i] = 8'd0;
			step_results_q.delete();
			mismatches = 0;
		end else begin
			if (instr_valid && instr_ready) begin
				step_results_q.push_back(execute_instr(instr));
			end
			if (result_valid && result_ready) begin
				if (step_results_q.size() == 0) begin
					$error("result beat with no instruction outstanding: next_ip %0d",
						result.next_ip);
					mismatches++;
				end else begin
					want = step_results_q.pop_front();
					check_field("next_ip", want.next_ip, result.next_ip);
					check_field("io_valid", 8'(want.io_valid), 8'(result.io_valid));
					check_field("io_data", want.io_data, result.io_data);
					check_field("halted", 8'(want.halted), 8'(result.halted));
				end
			end
		end
		outstanding = step_results_q.size();
	end

endmodule

/* dv/tb_tiny_cpu_instruction_step_core.sv */
module tb_tiny_cpu_instruction_step_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [4:0] OpSpare0  = 5'd0;
	localparam logic [4:0] OpSpare16 = 5'd16;
	localparam logic [4:0] OpSpare30 = 5'd30;
	localparam logic [4:0] OpSpare31 = 5'd31;

	localparam logic [3:0] RegNul    = 4'd0;
	localparam logic [3:0] RegRa     = 4'd2;
	localparam logic [3:0] RegRb     = 4'd3;
	localparam logic [3:0] RegRc     = 4'd4;
	localparam logic [3:0] RegRd     = 4'd5;
	localparam logic [3:0] RegRe     = 4'd6;
	localparam logic [3:0] RegBeyond = 4'd15;

	localparam int unsigned RandomInstrs = 1850;
	localparam int unsigned DrainEvery   = 400;

	logic           clk;
	logic           arst_n;
	logic           instr_valid;
	logic           instr_ready;
	tcis_pkg::in_t  instr;
	logic           result_valid;
	logic           result_ready;
	tcis_pkg::out_t result;
	int unsigned    mismatches;
	int unsigned    outstanding;
	int unsigned    burst_left;

	tiny_cpu_instruction_step_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.instr_valid  (instr_valid),
		.instr_ready  (instr_ready),
		.instr        (instr),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	tcis_step_checker step_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.instr_valid  (instr_valid),
		.instr_ready  (instr_ready),
		.instr        (instr),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	function automatic tcis_pkg::in_t reg_form(logic [4:0] op, logic [3:0] a,
			logic [3:0] b, logic [3:0] c);
		return {op, a, b[2:0], c};
	endfunction

	function automatic tcis_pkg::in_t imm_form(logic [4:0] op, logic [7:0] imm,
			logic [3:0] dest);
		return {op, imm, dest[2:0]};
	endfunction

	// Mostly real registers, now and then an index past the flag register.
	function automatic logic [3:0] pick_reg();
		logic [3:0] idx;
		if ($urandom_range(0, 9) == 0) begin
			idx = 4'($urandom_range(tcis_pkg::NumRegs, 15));
		end else begin
			idx = 4'($urandom_range(0, tcis_pkg::NumRegs - 1));
		end
		return idx;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned roll;
		int unsigned gap;
		roll = $urandom_range(0, 99);
		gap = 0;
		if (burst_left > 0) begin
			burst_left--;
		end else if (roll < 3) begin
			burst_left = $urandom_range(20, 80);
		end else if (roll < 55) begin
			gap = 0;
		end else if (roll < 85) begin
			gap = $urandom_range(1, 2);
		end else if (roll < 97) begin
			gap = $urandom_range(3, 8);
		end else begin
			gap = $urandom_range(15, 40);
		end
		return gap;
	endfunction

	function automatic tcis_pkg::in_t random_instr();
		int unsigned    roll;
		int unsigned    steps;
		tcis_pkg::op_e  op;
		tcis_pkg::in_t  ins;
		roll = $urandom_range(0, 99);
		if (roll < 50) begin
			op = op.first();
			steps = $urandom_range(0, op.num() - 1);
			repeat (steps) op = op.next();
			if (op == tcis_pkg::OP_LDI || op == tcis_pkg::OP_JMPI
					|| op == tcis_pkg::OP_PUSHI) begin
				ins = imm_form(op, 8'($urandom), 4'($urandom));
			end else begin
				ins = reg_form(op, pick_reg(), 4'($urandom), pick_reg());
			end
		end else if (roll < 70) begin
			case ($urandom_range(0, 2))
				0: ins = reg_form(tcis_pkg::OP_PUSH, pick_reg(), 4'($urandom), pick_reg());
				1: ins = imm_form(tcis_pkg::OP_PUSHI, 8'($urandom), 4'($urandom));
				default: ins = reg_form(tcis_pkg::OP_POP, 4'($urandom), 4'($urandom),
					pick_reg());
			endcase
		end else if (roll < 80) begin
			if ($urandom_range(0, 1) == 0) begin
				ins = reg_form(tcis_pkg::OP_JMP, pick_reg(), 4'($urandom), 4'($urandom));
			end else begin
				ins = imm_form(tcis_pkg::OP_JMPI, 8'($urandom), 4'($urandom));
			end
		end else if (roll < 86) begin
			if ($urandom_range(0, 1) == 0) begin
				ins = imm_form(tcis_pkg::OP_LDI, 8'($urandom), tcis_pkg::RegIo);
			end else begin
				ins = reg_form(tcis_pkg::OP_COPY, pick_reg(), 4'($urandom), tcis_pkg::RegIo);
			end
		end else if (roll < 92) begin
			case ($urandom_range(0, 2))
				0: ins = reg_form(tcis_pkg::OP_COPY, pick_reg(), 4'($urandom),
					tcis_pkg::RegRp);
				1: ins = reg_form(tcis_pkg::OP_ADD, pick_reg(), 4'($urandom),
					tcis_pkg::RegMem);
				default: ins = imm_form(tcis_pkg::OP_LDI, 8'($urandom), tcis_pkg::RegMem);
			endcase
		end else if (roll < 95) begin
			ins = {tcis_pkg::OP_HALT, 11'($urandom)};
		end else if (roll < 97) begin
			case ($urandom_range(0, 3))
				0: ins = {OpSpare0, 11'($urandom)};
				1: ins = {OpSpare16, 11'($urandom)};
				2: ins = {OpSpare30, 11'($urandom)};
				default: ins = {OpSpare31, 11'($urandom)};
			endcase
		end else begin
			ins = tcis_pkg::in_t'($urandom);
		end
		return ins;
	endfunction

	task automatic send_instr(tcis_pkg::in_t ins);
		int unsigned gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			instr_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		instr_valid <= 1'b1;
		instr <= ins;
		do @(posedge clk); while (!instr_ready);
	endtask

	task automatic drain();
		@(negedge clk);
		instr_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int unsigned stretch;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 99) < 65) begin
				result_ready <= 1'b1;
				stretch = $urandom_range(1, 50);
			end else begin
				result_ready <= 1'b0;
				stretch = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
					: $urandom_range(10, 40);
			end
			repeat (stretch - 1) @(negedge clk);
		end
	end

	initial begin
		arst_n = 1'b0;
		instr_valid = 1'b0;
		instr = '0;
		burst_left = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		send_instr(imm_form(tcis_pkg::OP_LDI, 8'hFF, RegRa));
		send_instr(imm_form(tcis_pkg::OP_LDI, 8'd8, RegRb));
		// Shift amounts of eight or more clear the result.
		send_instr(reg_form(tcis_pkg::OP_SHL, RegRa, RegRb, RegRc));
		send_instr(reg_form(tcis_pkg::OP_SHR, RegRa, RegRb, RegRd));
		send_instr(reg_form(tcis_pkg::OP_MUL, RegRa, RegRb, RegRc));
		// All operand bits set: reads and writes an index past the register file.
		send_instr(reg_form(tcis_pkg::OP_ADD, RegBeyond, 4'd7, RegBeyond));
		send_instr(imm_form(tcis_pkg::OP_LDI, 8'h5A, RegNul));
		send_instr(imm_form(tcis_pkg::OP_LDI, 8'hFF, tcis_pkg::RegIo));
		send_instr(reg_form(tcis_pkg::OP_COPY, tcis_pkg::RegIo, RegNul, tcis_pkg::RegIo));
		send_instr(imm_form(tcis_pkg::OP_PUSHI, 8'hAA, RegNul));
		send_instr(reg_form(tcis_pkg::OP_PUSH, RegRa, RegNul, RegNul));
		send_instr(reg_form(tcis_pkg::OP_POP, RegNul, RegNul, RegRe));
		// Stack pointer far past the RAM depth wraps the address.
		send_instr(imm_form(tcis_pkg::OP_LDI, 8'hC8, RegRc));
		send_instr(reg_form(tcis_pkg::OP_COPY, RegRc, RegNul, tcis_pkg::RegRp));
		send_instr(reg_form(tcis_pkg::OP_COPY, RegRa, RegNul, tcis_pkg::RegMem));
		send_instr(reg_form(tcis_pkg::OP_GT, RegRa, RegRb, RegNul));
		send_instr(imm_form(tcis_pkg::OP_JMPI, 8'h40, RegNul));
		send_instr(reg_form(tcis_pkg::OP_JMP, RegRa, RegNul, RegNul));
		// Writing the instruction pointer with its own value still advances it.
		send_instr(reg_form(tcis_pkg::OP_COPY, tcis_pkg::RegIp, RegNul, tcis_pkg::RegIp));
		send_instr(reg_form(tcis_pkg::OP_EQ, RegRa, RegRb, RegNul));
		send_instr(imm_form(tcis_pkg::OP_JMPI, 8'h10, RegNul));
		send_instr({tcis_pkg::OP_HALT, 11'($urandom)});
		send_instr({OpSpare0, 11'($urandom)});
		send_instr({OpSpare16, 11'($urandom)});
		send_instr({OpSpare30, 11'($urandom)});
		send_instr({OpSpare31, 11'($urandom)});
		drain();

		for (int unsigned i = 0; i < RandomInstrs; i++) begin
			send_instr(random_instr());
			if (i % DrainEvery == DrainEvery - 1) begin
				drain();
			end
		end
		drain();
		repeat (10) @(negedge clk);

		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

/* tiny_cpu_instruction_step_core.f */
hw/rtl/tcis_pkg.sv
hw/rtl/tcis_exec.sv
hw/rtl/tcis_stack_ram.sv
hw/rtl/tiny_cpu_instruction_step_core.sv
hw/rtl/tcis_checker.sv
dv/tcis_step_checker.sv
dv/tb_tiny_cpu_instruction_step_core.sv
